// ----- sv/iso14443a_anticollision_sequencer_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef ISO14443A_ANTICOLLISION_SEQUENCER_CORE_ASSERT_SVH
`define ISO14443A_ANTICOLLISION_SEQUENCER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/iaseq_pkg.sv -----
package iaseq_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ATQA = 2'd1,
    PH_UID  = 2'd2,
    PH_SAK  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TX   = 3'd0,
    KIND_ATQA = 3'd1,
    KIND_SAK  = 3'd2,
    KIND_UID  = 3'd3,
    KIND_TAG  = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic       OP_START = 1'b0;

  localparam logic [7:0] CMD_WUPA     = 8'h52;
  localparam logic [7:0] CMD_REQA     = 8'h26;
  localparam logic [7:0] CT_BYTE      = 8'h88;
  localparam logic [7:0] NVB_ANTICOLL = 8'h20;
  localparam logic [7:0] NVB_SELECT   = 8'h70;
  localparam logic [7:0] SAK_CASCADE  = 8'h04;

  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;

  // One accepted input item.
  typedef struct packed {
    logic       op;
    logic [1:0] status;
    logic [5:0] rx_len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } item_t;

  // One result.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       crc_on;
    logic       found;
  } res_t;

  function automatic logic [7:0] sel_code(input logic [1:0] lvl);
    case (lvl)
      2'd0:    sel_code = 8'h93;
      2'd1:    sel_code = 8'h95;
      default: sel_code = 8'h97;
    endcase
  endfunction

endpackage

// ----- sv/iaseq_front.sv -----
// Input queue: accepts items and hands them to the back end in order.
module iaseq_front #(
  parameter int Depth = iaseq_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  iaseq_pkg::item_t   item_in,
  output logic               item_valid,
  input  logic               item_take,
  output iaseq_pkg::item_t   item_out
);
  import iaseq_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t            mem_r [Depth];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full       = (cnt_r == (AW+1)'(Depth));
  assign item_valid = (cnt_r != '0);
  assign item_out   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = item_valid && item_take;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ----- sv/iaseq_back.sv -----
// Sequencer: takes one item, then emits its results one per cycle while the result queue has room.
module iaseq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              use_reqa,
  input  logic              item_valid,
  output logic              item_take,
  input  iaseq_pkg::item_t  item,
  output logic              res_valid,
  input  logic              res_ready,
  output iaseq_pkg::res_t   res
);
  import iaseq_pkg::*;

  // Emission programs, one per kind of step.
  typedef enum logic [2:0] {
    PR_NONE, PR_START, PR_FAIL, PR_ATQA, PR_SEL, PR_SAKNEXT, PR_SAKDONE
  } prog_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic [3:0]  ulen_r, ulen_nxt;
  logic        tagp_r, tagp_nxt;
  logic [7:0]  uid_r [10];
  prog_t       prog_r, prog_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  b0_r, b1_r, b2_r, b3_r, bcc_r;
  logic        busy_r, busy_nxt;
  logic        ok_st;
  logic [3:0]  base;
  logic        ct;
  logic        wr_uid;

  assign ok_st     = (item.status == ST_OK);
  assign base      = 4'(lvl_r) * 4'd3;
  assign ct        = (item.b0 == CT_BYTE);
  assign item_take = !busy_r;

  // Decode step, and advance through the emission slots.
  always_comb begin
    phase_nxt = phase_r;
    lvl_nxt   = lvl_r;
    ulen_nxt  = ulen_r;
    tagp_nxt  = tagp_r;
    prog_nxt  = prog_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    wr_uid    = 1'b0;
    if (!busy_r && item_valid) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
      prog_nxt = PR_NONE;
      if (item.op == OP_START) begin
        phase_nxt = PH_ATQA;
        lvl_nxt   = '0;
        ulen_nxt  = '0;
        tagp_nxt  = 1'b0;
        prog_nxt  = PR_START;
      end else begin
        case (phase_r)
          PH_ATQA: begin
            if (!ok_st || item.rx_len != 6'd2) begin
              prog_nxt = PR_FAIL; phase_nxt = PH_IDLE;
            end else begin
              prog_nxt = PR_ATQA; phase_nxt = PH_UID;
            end
          end
          PH_UID: begin
            if (!ok_st || item.rx_len != 6'd5 || (lvl_r == 2'd2 && ct)) begin
              prog_nxt = PR_FAIL; phase_nxt = PH_IDLE;
            end else begin
              wr_uid    = 1'b1;
              ulen_nxt  = base + (ct ? 4'd3 : 4'd4);
              tagp_nxt  = ct;
              prog_nxt  = PR_SEL;
              phase_nxt = PH_SAK;
            end
          end
          PH_SAK: begin
            if (!ok_st || item.rx_len != 6'd1
                || (tagp_r && (item.b0 & SAK_CASCADE) == 8'h00)
                || (tagp_r && lvl_r == 2'd2)) begin
              prog_nxt = PR_FAIL; phase_nxt = PH_IDLE;
            end else if (tagp_r) begin
              lvl_nxt = lvl_r + 2'd1; prog_nxt = PR_SAKNEXT; phase_nxt = PH_UID;
            end else begin
              prog_nxt = PR_SAKDONE; phase_nxt = PH_IDLE;
            end
          end
          default: begin
            busy_nxt = 1'b0;
          end
        endcase
      end
    end else if (busy_r && res_ready) begin
      idx_nxt = idx_r + 4'd1;
      if (res.last && (prog_r != PR_ATQA || idx_r == 4'd3)
          && (prog_r != PR_SAKNEXT || idx_r == 4'd2)
          && (prog_r != PR_SAKDONE || res.kind == KIND_TAG)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Result of the current emission slot.
  always_comb begin
    res = '{kind: KIND_TX, data: 8'h00, last: 1'b0, crc_on: 1'b0, found: 1'b0};
    case (prog_r)
      PR_START: begin
        res.data = use_reqa ? CMD_REQA : CMD_WUPA; res.last = 1'b1;
      end
      PR_FAIL: begin
        res.kind = KIND_TAG; res.last = 1'b1;
      end
      PR_ATQA: begin
        case (idx_r)
          4'd0: begin res.kind = KIND_ATQA; res.data = b0_r; end
          4'd1: begin res.kind = KIND_ATQA; res.data = b1_r; res.last = 1'b1; end
          4'd2: res.data = sel_code(lvl_r);
          default: begin res.data = NVB_ANTICOLL; res.last = 1'b1; end
        endcase
      end
      PR_SEL: begin
        res.crc_on = 1'b1;
        case (idx_r)
          4'd0: res.data = sel_code(lvl_r);
          4'd1: res.data = NVB_SELECT;
          4'd2: res.data = b0_r;
          4'd3: res.data = b1_r;
          4'd4: res.data = b2_r;
          4'd5: res.data = b3_r;
          default: begin res.data = bcc_r; res.last = 1'b1; end
        endcase
      end
      PR_SAKNEXT: begin
        case (idx_r)
          4'd0: begin res.kind = KIND_SAK; res.data = b0_r; res.last = 1'b1; end
          4'd1: res.data = sel_code(lvl_r);
          default: begin res.data = NVB_ANTICOLL; res.last = 1'b1; end
        endcase
      end
      PR_SAKDONE: begin
        if (idx_r == 4'd0) begin
          res.kind = KIND_SAK; res.data = b0_r; res.last = 1'b1;
        end else if (idx_r <= ulen_r && idx_r <= 4'd10) begin
          res.kind = KIND_UID;
          res.data = uid_r[idx_r - 4'd1];
          res.last = (idx_r == ulen_r);
        end else begin
          res.kind = KIND_TAG; res.data = 8'h01; res.last = 1'b1; res.found = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_valid = busy_r && (prog_r != PR_NONE);

  always_ff @(posedge clk) begin
    if (!busy_r && item_valid) begin
      b0_r  <= item.b0;
      b1_r  <= item.b1;
      b2_r  <= item.b2;
      b3_r  <= item.b3;
      bcc_r <= item.b0 ^ item.b1 ^ item.b2 ^ item.b3;
    end
    if (wr_uid) begin
      if (ct) begin
        uid_r[base]        <= item.b1;
        uid_r[base + 4'd1] <= item.b2;
        uid_r[base + 4'd2] <= item.b3;
      end else begin
        uid_r[base]        <= item.b0;
        uid_r[base + 4'd1] <= item.b1;
        uid_r[base + 4'd2] <= item.b2;
        uid_r[base + 4'd3] <= item.b3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      lvl_r   <= '0;
      ulen_r  <= '0;
      tagp_r  <= 1'b0;
      prog_r  <= PR_NONE;
      idx_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      lvl_r   <= lvl_nxt;
      ulen_r  <= ulen_nxt;
      tagp_r  <= tagp_nxt;
      prog_r  <= prog_nxt;
      idx_r   <= idx_nxt;
      busy_r  <= (prog_nxt == PR_NONE) ? 1'b0 : busy_nxt;
    end
  end
endmodule

// ----- sv/iaseq_outq.sv -----
// Result queue between the sequencer and the result port.
module iaseq_outq #(
  parameter int Depth = iaseq_pkg::OUT_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  iaseq_pkg::res_t  wr_data,
  output logic             empty,
  input  logic             pop,
  output iaseq_pkg::res_t  rd_data
);
  import iaseq_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  res_t          mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign empty    = (cnt_r == '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule

// ----- sv/iso14443a_anticollision_sequencer_core.sv -----
// Channel | Direction | Handshake          | Payload
// input   | in        | in_push / in_full  | in_op, in_status, in_rx_len, in_rx_b0..in_rx_b4
// result  | out       | out_empty / out_pop| out_kind, out_data, out_last, out_crc_on, out_found
// config  | in        | cfg_valid/cfg_ready| cfg_use_reqa
//
// An item is decoded, then its results are emitted, up to twelve of them; a
// response while idle is decoded and has no result.
// Reset is synchronous and active low; it clears all control state.
// A full result queue stalls the sequencer, and the input queue then fills
// and raises in_full; until it is full the input side keeps taking transfers.
module iso14443a_anticollision_sequencer_core #(
  parameter int InDepth  = iaseq_pkg::QUEUE_DEPTH,
  parameter int OutDepth = iaseq_pkg::OUT_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_op,
  input  logic [1:0] in_status,
  input  logic [5:0] in_rx_len,
  input  logic [7:0] in_rx_b0,
  input  logic [7:0] in_rx_b1,
  input  logic [7:0] in_rx_b2,
  input  logic [7:0] in_rx_b3,
  input  logic [7:0] in_rx_b4,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_kind,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       out_crc_on,
  output logic       out_found,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_use_reqa
);
  import iaseq_pkg::*;

  item_t item_in, item_q;
  logic  item_valid, item_take;
  res_t  res_w, res_q;
  logic  res_valid, res_ready;
  logic  use_reqa_r;

  // The configuration register accepts a transfer in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_reqa_r <= 1'b0;
    end else if (cfg_valid) begin
      use_reqa_r <= cfg_use_reqa;
    end
  end

  assign item_in = '{op: in_op, status: in_status, rx_len: in_rx_len,
                     b0: in_rx_b0, b1: in_rx_b1, b2: in_rx_b2,
                     b3: in_rx_b3, b4: in_rx_b4};

  iaseq_front #(.Depth(InDepth)) u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .item_in,
    .item_valid, .item_take, .item_out(item_q)
  );

  iaseq_back u_back (
    .clk, .rst_n, .use_reqa(use_reqa_r), .item_valid, .item_take,
    .item(item_q), .res_valid, .res_ready, .res(res_w)
  );

  iaseq_outq #(.Depth(OutDepth)) u_outq (
    .clk, .rst_n, .wr_valid(res_valid), .wr_ready(res_ready),
    .wr_data(res_w), .empty(out_empty), .pop(out_pop), .rd_data(res_q)
  );

  assign out_kind   = res_q.kind;
  assign out_data   = res_q.data;
  assign out_last   = res_q.last;
  assign out_crc_on = res_q.crc_on;
  assign out_found  = res_q.found;
endmodule

// ----- sv/iaseq_checker.sv -----
`include "iso14443a_anticollision_sequencer_core_assert.svh"
module iaseq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_kind,
  input logic [7:0] out_data,
  input logic       out_last,
  input logic       out_crc_on,
  input logic       out_found
);
  import iaseq_pkg::*;

  `SEQ_ASSERT_IMP(a_found_tag, clk, rst_n, !out_empty && out_found, out_kind == KIND_TAG)
  `SEQ_ASSERT_IMP(a_tag_last, clk, rst_n, !out_empty && out_kind == KIND_TAG, out_last)
  `SEQ_ASSERT_IMP(a_crc_tx, clk, rst_n, !out_empty && out_crc_on, out_kind == KIND_TX)
  `SEQ_ASSERT_NXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_data))
endmodule

bind iso14443a_anticollision_sequencer_core iaseq_checker u_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_kind, .out_data, .out_last,
  .out_crc_on, .out_found
);

// ----- dv/iso14443a_anticollision_sequencer_core_tb.sv -----
module iso14443a_anticollision_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iaseq_pkg::*;

  // Select codes per cascade level; the fourth entry repeats the third.
  localparam logic [7:0] SEL_CODE [4] = '{8'h93, 8'h95, 8'h97, 8'h97};
  localparam int WATCHDOG_LIMIT = 4000;
  // Covers decoding an item and emitting up to twelve results, with margin; also covers items with no result.
  localparam int SETTLE_CYCLES = 40;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_op;
  logic [1:0] in_status;
  logic [5:0] in_rx_len;
  logic [7:0] in_rx_b0, in_rx_b1, in_rx_b2, in_rx_b3, in_rx_b4;
  logic       out_empty;
  logic       out_pop;
  logic [2:0] out_kind;
  logic [7:0] out_data;
  logic       out_last;
  logic       out_crc_on;
  logic       out_found;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_use_reqa;

  iso14443a_anticollision_sequencer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_op       (in_op),
    .in_status   (in_status),
    .in_rx_len   (in_rx_len),
    .in_rx_b0    (in_rx_b0),
    .in_rx_b1    (in_rx_b1),
    .in_rx_b2    (in_rx_b2),
    .in_rx_b3    (in_rx_b3),
    .in_rx_b4    (in_rx_b4),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_kind    (out_kind),
    .out_data    (out_data),
    .out_last    (out_last),
    .out_crc_on  (out_crc_on),
    .out_found   (out_found),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_use_reqa(cfg_use_reqa)
  );

  // Responses waiting to be pushed, and the results we expect to pop, oldest first.
  item_t pending_items[$];
  res_t  expected_results[$];
  item_t item_on_bus;

  // Shadow copy of the sequencer's control state.
  phase_t     seq_phase;
  logic [1:0] seq_level;
  logic [7:0] seq_uid [10];
  logic [3:0] seq_uid_len;
  logic       seq_ct_seen;
  logic       seq_use_reqa;

  int  error_count;
  int  stall_cycles;
  bit  quiet;
  int  push_gap;
  int  pop_gap;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic res_t mk_res(kind_t k, logic [7:0] d, logic l, logic c, logic f);
    res_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    r.crc_on = c;
    r.found = f;
    return r;
  endfunction

  // A failed step reports an absent tag and drops back to idle.
  function automatic void abort_activation();
    seq_phase = PH_IDLE;
    expected_results.push_back(mk_res(KIND_TAG, 8'h00, 1'b1, 1'b0, 1'b0));
  endfunction

  function automatic void send_anticoll();
    expected_results.push_back(mk_res(KIND_TX, SEL_CODE[seq_level], 1'b0, 1'b0, 1'b0));
    expected_results.push_back(mk_res(KIND_TX, NVB_ANTICOLL, 1'b1, 1'b0, 1'b0));
  endfunction

  // Advances the shadow state by one accepted item and queues the results it causes.
  function automatic void advance_activation(item_t it);
    logic [7:0] bcc;
    int base;
    bit more;
    if (it.op == OP_START) begin
      seq_phase = PH_ATQA;
      seq_level = 2'd0;
      seq_uid_len = 4'd0;
      seq_ct_seen = 1'b0;
      expected_results.push_back(mk_res(KIND_TX, seq_use_reqa ? CMD_REQA : CMD_WUPA,
                                        1'b1, 1'b0, 1'b0));
      return;
    end
    case (seq_phase)
      PH_ATQA: begin
        if (it.status != ST_OK || it.rx_len != 6'd2) begin
          abort_activation();
        end else begin
          expected_results.push_back(mk_res(KIND_ATQA, it.b0, 1'b0, 1'b0, 1'b0));
          expected_results.push_back(mk_res(KIND_ATQA, it.b1, 1'b1, 1'b0, 1'b0));
          seq_phase = PH_UID;
          send_anticoll();
        end
      end
      PH_UID: begin
        if (it.status != ST_OK || it.rx_len != 6'd5 ||
            (seq_level >= 2'd2 && it.b0 == CT_BYTE)) begin
          abort_activation();
        end else begin
          base = 3 * seq_level;
          if (it.b0 == CT_BYTE) begin
            seq_uid[(base + 0) % 10] = it.b1;
            seq_uid[(base + 1) % 10] = it.b2;
            seq_uid[(base + 2) % 10] = it.b3;
            seq_uid_len = 4'(base + 3);
            seq_ct_seen = 1'b1;
          end else begin
            seq_uid[(base + 0) % 10] = it.b0;
            seq_uid[(base + 1) % 10] = it.b1;
            seq_uid[(base + 2) % 10] = it.b2;
            seq_uid[(base + 3) % 10] = it.b3;
            seq_uid_len = 4'(base + 4);
            seq_ct_seen = 1'b0;
          end
          // The received check byte is ignored; the select frame carries our own.
          bcc = it.b0 ^ it.b1 ^ it.b2 ^ it.b3;
          expected_results.push_back(mk_res(KIND_TX, SEL_CODE[seq_level], 1'b0, 1'b1, 1'b0));
          expected_results.push_back(mk_res(KIND_TX, NVB_SELECT, 1'b0, 1'b1, 1'b0));
          expected_results.push_back(mk_res(KIND_TX, it.b0, 1'b0, 1'b1, 1'b0));
          expected_results.push_back(mk_res(KIND_TX, it.b1, 1'b0, 1'b1, 1'b0));
          expected_results.push_back(mk_res(KIND_TX, it.b2, 1'b0, 1'b1, 1'b0));
          expected_results.push_back(mk_res(KIND_TX, it.b3, 1'b0, 1'b1, 1'b0));
          expected_results.push_back(mk_res(KIND_TX, bcc, 1'b1, 1'b1, 1'b0));
          seq_phase = PH_SAK;
        end
      end
      PH_SAK: begin
        more = (it.b0 & SAK_CASCADE) != 8'h00;
        if (it.status != ST_OK || it.rx_len != 6'd1 ||
            (seq_ct_seen && !more) || (seq_ct_seen && seq_level >= 2'd2)) begin
          abort_activation();
        end else begin
          expected_results.push_back(mk_res(KIND_SAK, it.b0, 1'b1, 1'b0, 1'b0));
          if (seq_ct_seen) begin
            seq_level = seq_level + 2'd1;
            seq_phase = PH_UID;
            send_anticoll();
          end else begin
            for (int i = 0; i < seq_uid_len && i < 10; i++)
              expected_results.push_back(mk_res(KIND_UID, seq_uid[i],
                                                (i + 1 == seq_uid_len), 1'b0, 1'b0));
            seq_phase = PH_IDLE;
            expected_results.push_back(mk_res(KIND_TAG, 8'h01, 1'b1, 1'b0, 1'b1));
          end
        end
      end
      default: ;  // Responses while idle are dropped.
    endcase
  endfunction

  function automatic item_t mk_item(logic op, logic [1:0] st, logic [5:0] len,
                                    logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3, logic [7:0] b4);
    item_t it;
    it.op = op;
    it.status = st;
    it.rx_len = len;
    it.b0 = b0;
    it.b1 = b1;
    it.b2 = b2;
    it.b3 = b3;
    it.b4 = b4;
    return it;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t noise_item();
    return mk_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   6'($urandom_range(0, 63)), rnd_byte(), rnd_byte(), rnd_byte(),
                   rnd_byte(), rnd_byte());
  endfunction

  // A response that is well formed except, now and then, for its status or length.
  function automatic item_t response(logic [5:0] len, logic [7:0] b0, int corrupt_pct);
    item_t it;
    it = mk_item(1'b1, ST_OK, len, b0, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    if ($urandom_range(1, 100) <= corrupt_pct) begin
      if ($urandom_range(0, 1)) it.status = 2'($urandom_range(1, 3));
      else it.rx_len = 6'($urandom_range(0, 63));
    end
    return it;
  endfunction

  // Queues one complete activation with up to three cascade levels.
  function automatic void queue_activation(int corrupt_pct);
    int ct_levels;
    bit ct;
    logic [7:0] b0;
    logic [7:0] sak;
    ct_levels = $urandom_range(0, 2);
    pending_items.push_back(mk_item(OP_START, 2'($urandom_range(0, 3)),
                                    6'($urandom_range(0, 63)),
                                    rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
                                    rnd_byte()));
    pending_items.push_back(response(6'd2, rnd_byte(), corrupt_pct));
    for (int l = 0; l <= ct_levels; l++) begin
      ct = (l < ct_levels);
      b0 = rnd_byte();
      if (ct) b0 = CT_BYTE;
      else if (b0 == CT_BYTE) b0 = 8'h08;
      // Sometimes a cascade tag shows up at the third level.
      if (l == 2 && $urandom_range(1, 100) <= corrupt_pct) b0 = CT_BYTE;
      pending_items.push_back(response(6'd5, b0, corrupt_pct));
      sak = rnd_byte();
      if (ct) sak = sak | SAK_CASCADE;
      if (ct && $urandom_range(1, 100) <= corrupt_pct) sak = sak & ~SAK_CASCADE;
      pending_items.push_back(response(6'd1, sak, corrupt_pct));
    end
  endfunction

  // Waits until every queued item went in and every expected result came out,
  // then lets the block finish anything that produces no result.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_push || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_use_reqa(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_use_reqa <= v;
    do @(posedge clk); while (!cfg_ready);
    seq_use_reqa = v;
    cfg_valid <= 1'b0;
  endtask

  // Driver: a new item goes on the bus only once the previous one transferred.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) advance_activation(item_on_bus);
      if (!in_push || !in_full) begin
        if (push_gap > 0) begin
          push_gap <= push_gap - 1;
          in_push <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_on_bus = pending_items.pop_front();
          in_push <= 1'b1;
          in_op <= item_on_bus.op;
          in_status <= item_on_bus.status;
          in_rx_len <= item_on_bus.rx_len;
          in_rx_b0 <= item_on_bus.b0;
          in_rx_b1 <= item_on_bus.b1;
          in_rx_b2 <= item_on_bus.b2;
          in_rx_b3 <= item_on_bus.b3;
          in_rx_b4 <= item_on_bus.b4;
          if (!quiet && $urandom_range(0, 3) == 0) push_gap <= $urandom_range(1, 5);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each popped result against the oldest expectation and
  // stalls pop in short random bursts.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d data=%02h last=%0b crc_on=%0b found=%0b",
                   $realtime, out_kind, out_data, out_last, out_crc_on, out_found);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if ({want.kind, want.data, want.last, want.crc_on, want.found} !==
              {out_kind, out_data, out_last, out_crc_on, out_found}) begin
            $display("%0t: result mismatch expected kind=%0d data=%02h last=%0b crc_on=%0b found=%0b",
                     $realtime, want.kind, want.data, want.last, want.crc_on, want.found);
            $display("%0t:                 actual   kind=%0d data=%02h last=%0b crc_on=%0b found=%0b",
                     $realtime, out_kind, out_data, out_last, out_crc_on, out_found);
            error_count++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop_gap <= $urandom_range(0, 4);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = 1'b0;
    in_status = 2'd0;
    in_rx_len = 6'd0;
    in_rx_b0 = 8'h00;
    in_rx_b1 = 8'h00;
    in_rx_b2 = 8'h00;
    in_rx_b3 = 8'h00;
    in_rx_b4 = 8'h00;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_use_reqa = 1'b0;
    error_count = 0;
    stall_cycles = 0;
    quiet = 1'b0;
    push_gap = 0;
    pop_gap = 0;
    seq_phase = PH_IDLE;
    seq_level = 2'd0;
    seq_uid_len = 4'd0;
    seq_ct_seen = 1'b0;
    seq_use_reqa = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with WUPA as the start command.
    write_use_reqa(1'b0);
    // A response while idle is dropped without any result.
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Bad status on the ATQA, then a wrong ATQA length.
    pending_items.push_back(mk_item(OP_START, 2'd3, 6'd63, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    pending_items.push_back(mk_item(1'b1, 2'd1, 6'd2, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(OP_START, ST_OK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd63, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00));
    // Full triple-size UID with extreme byte values; a restart in the middle first.
    pending_items.push_back(mk_item(OP_START, ST_OK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd2, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(OP_START, ST_OK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd2, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, CT_BYTE, 8'hFF, 8'h00, 8'hFF, 8'h12));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, CT_BYTE, 8'h00, 8'hFF, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, SAK_CASCADE, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();

    // Scenarios that fail late, and one that completes, now with REQA as the start command.
    write_use_reqa(1'b1);
    // Cascade bit missing from the SAK after a cascade tag.
    pending_items.push_back(mk_item(OP_START, ST_OK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd2, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, CT_BYTE, 8'h01, 8'h02, 8'h03, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00));
    // Cascade tag at the third level.
    pending_items.push_back(mk_item(OP_START, ST_OK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd2, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, CT_BYTE, 8'h01, 8'h02, 8'h03, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, CT_BYTE, 8'h04, 8'h05, 8'h06, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, CT_BYTE, 8'h07, 8'h08, 8'h09, 8'h00));
    // Cascade bit set without a cascade tag still completes a single-size UID.
    pending_items.push_back(mk_item(OP_START, ST_OK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd2, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd5, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h00));
    pending_items.push_back(mk_item(1'b1, ST_OK, 6'd1, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();

    // Random part: mostly well-formed activations, some noise, several settings.
    for (int p = 0; p < 6; p++) begin
      write_use_reqa(p == 5 ? 1'b0 : logic'($urandom_range(0, 1)));
      if (p == 5) quiet = 1'b1;
      for (int n = 0; n < 8; n++) begin
        if ($urandom_range(0, 4) == 0) pending_items.push_back(noise_item());
        queue_activation(p < 2 ? 5 : 20);
      end
      wait_drained();
    end

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $realtime,
                 expected_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
